// ----- src/tdf_pkg.sv -----
// Package for the timestamp de-jitter filter: widths, fixed constants,
// codes, divider request and response types and saturation helpers.
// No dependencies; every other file of the block imports it.
package tdf_pkg;

	// Field and datapath widths.
	localparam int TIME_W    = 48;
	localparam int FRAC_W    = 16;
	localparam int WIDE_W    = 50;
	localparam int COUNT_W   = 6;
	localparam int SCALE_W   = 24;
	localparam int MUL_A_W   = TIME_W - FRAC_W;
	localparam int PROD_W    = MUL_A_W + SCALE_W;
	localparam int ACC_W     = PROD_W + 1;

	// Configuration port.
	localparam int PDATA_W     = 32;
	localparam int PADDR_W     = 3;
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_TIME_SCALE     = 1'b0;
	localparam logic REG_FILTER_DISABLE = 1'b1;

	// Serial divider: four quotient bits per cycle.
	localparam int DIV_W             = 52;
	localparam int DIVISOR_W         = 5;
	localparam int DIV_BITS_PER_STEP = 4;
	localparam int DIV_STEPS         = DIV_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = 4;

	// Operation codes of an input beat.
	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Which update an item takes.
	localparam logic [1:0] PATH_RESTART = 2'd0;
	localparam logic [1:0] PATH_SCALED  = 2'd1;
	localparam logic [1:0] PATH_HISTORY = 2'd2;

	// Fixed constants of the filter.
	localparam logic [SCALE_W-1:0]        UNITY_SCALE    = 24'h01_0000;
	localparam logic [TIME_W-1:0]         CLAMP_WINDOW   = 48'h0000_0010_0000;
	localparam logic signed [TIME_W-1:0]  FIRST_DELTA    = 48'sd1092239;
	localparam logic signed [COUNT_W-1:0] COUNT_RESET    = -6'sd2;
	localparam logic [DIVISOR_W-1:0]      SMOOTH_DIVISOR = 5'd10;
	localparam logic [WIDE_W:0]           SMOOTH_ROUND   = 51'd5;

	// Saturation limits.
	localparam logic [TIME_W-1:0]        S48_MAX   = 48'h7FFF_FFFF_FFFF;
	localparam logic [TIME_W-1:0]        S48_MIN   = 48'h8000_0000_0000;
	localparam logic signed [WIDE_W-1:0] S48_MAX_W = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] S48_MIN_W = 50'sh3_8000_0000_0000;
	localparam logic signed [WIDE_W-1:0] U48_MAX_W = 50'sh0_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// Clamp a wide signed value to the signed 48-bit range.
	function automatic logic signed [TIME_W-1:0] sat_signed(input logic signed [WIDE_W-1:0] v);
		logic signed [TIME_W-1:0] r;
		if (v > S48_MAX_W) begin
			r = S48_MAX;
		end else if (v < S48_MIN_W) begin
			r = S48_MIN;
		end else begin
			r = v[TIME_W-1:0];
		end
		return r;
	endfunction

	// Clamp a wide signed value to the unsigned 48-bit range.
	function automatic logic [TIME_W-1:0] sat_unsigned(input logic signed [WIDE_W-1:0] v);
		logic [TIME_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > U48_MAX_W) begin
			r = '1;
		end else begin
			r = v[TIME_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/tdf_stream_if.sv -----
// Valid/ready channel interfaces for input samples and filtered results.
// Depends on tdf_pkg for the field widths.
interface tdf_in_if import tdf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [TIME_W-1:0] raw_time;

	modport source (output valid, operation, raw_time, input ready);
	modport sink (input valid, operation, raw_time, output ready);
endinterface

interface tdf_out_if import tdf_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [TIME_W-1:0]        filtered_time;
	logic signed [TIME_W-1:0] frame_delta;

	modport source (output valid, filtered_time, frame_delta, input ready);
	modport sink (input valid, filtered_time, frame_delta, output ready);
endinterface

// ----- src/tdf_divider.sv -----
// Shared restoring divider, four quotient bits per cycle, for the mean
// period and the smoothing step. Depends on tdf_pkg.
module tdf_divider import tdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W-1:0]     quo_nx;
	logic [DIVISOR_W-1:0] rem_nx;

	// Four dependent restoring steps on the narrow remainder.
	always_comb begin
		logic [DIVISOR_W:0] trial;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
			trial  = {rem_nx, quo_nx[DIV_W-1]};
			quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				trial     = trial - {1'b0, dsr_q};
				quo_nx[0] = 1'b1;
			end
			rem_nx = trial[DIVISOR_W-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	// Dividend shifts into the quotient, remainder beside it.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- src/tdf_history.sv -----
// Ring memory of raw timestamps: one write port, one registered read port.
// Depends on tdf_pkg for the timestamp width.
module tdf_history import tdf_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [TIME_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [TIME_W-1:0] rdata
);

	logic [TIME_W-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/timestamp_dejitter_filter_top.sv -----
// Timestamp de-jitter filter, top level. A smoothed sample makes two passes through the shared
// 4-bit-per-cycle divider, mean period and then smoothing step, or only the first while the
// smoothed period is still zero. Raw-follow and restart beats skip the divider; scaled beats use
// the shared 32x24 multiplier instead. One item is in work at a time; a finished result waits in
// the output register while the next beat is taken. arst_n clears the filter state and the
// configuration registers at once; history, working registers and output data have no reset.
module timestamp_dejitter_filter_top import tdf_pkg::*; #(
	parameter int HISTORY_DEPTH = 32,
	parameter int MAX_SPAN      = 30,
	parameter int ENGAGE_COUNT  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	tdf_in_if.sink             timestamp,
	tdf_out_if.source          smoothed
);

	localparam int AW     = $clog2(HISTORY_DEPTH);
	localparam int SPAN_W = COUNT_W + 1;
	localparam logic signed [COUNT_W-1:0] ENGAGE_S = $signed(COUNT_W'(ENGAGE_COUNT));
	localparam logic signed [COUNT_W-1:0] MAX_SPAN_S = $signed(COUNT_W'(MAX_SPAN));

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_RD_NEWEST = 4'd1;
	localparam logic [3:0] S_RD_OLDEST = 4'd2;
	localparam logic [3:0] S_DIFF      = 4'd3;
	localparam logic [3:0] S_DIV_MEAN  = 4'd4;
	localparam logic [3:0] S_STEP      = 4'd5;
	localparam logic [3:0] S_DIV_STEP  = 4'd6;
	localparam logic [3:0] S_SMOOTH    = 4'd7;
	localparam logic [3:0] S_PRED      = 4'd8;
	localparam logic [3:0] S_CLAMP     = 4'd9;
	localparam logic [3:0] S_FLOOR     = 4'd10;
	localparam logic [3:0] S_MUL_HI    = 4'd11;
	localparam logic [3:0] S_MUL_LO    = 4'd12;
	localparam logic [3:0] S_MUL_ACC   = 4'd13;
	localparam logic [3:0] S_SAT       = 4'd14;
	localparam logic [3:0] S_OUT       = 4'd15;

	// Control and filter state.
	logic [3:0]                state_q;
	logic [1:0]                path_q;
	logic [SCALE_W-1:0]        time_scale_q;
	logic                      filter_disable_q;
	logic [AW-1:0]             wp_q;
	logic signed [COUNT_W-1:0] cnt_q;
	logic signed [TIME_W-1:0]  sp_q;
	logic [TIME_W-1:0]         last_out_q;
	logic [TIME_W-1:0]         last_raw_q;
	logic                      last_raw_valid_q;
	logic                      res_valid_q;

	// Working registers.
	logic [TIME_W-1:0]         raw_q;
	logic [TIME_W-1:0]         mag_q;
	logic                      neg_q;
	logic [ACC_W-1:0]          acc_q;
	logic [PROD_W-1:0]         prod_q;
	logic [TIME_W-1:0]         newest_q;
	logic signed [WIDE_W-1:0]  mean_q;
	logic                      sgn_q;
	logic signed [WIDE_W-1:0]  pred_q;
	logic [TIME_W-1:0]         sample_q;
	logic signed [TIME_W-1:0]  delta_q;
	logic [TIME_W-1:0]         res_time_q;
	logic signed [TIME_W-1:0]  res_delta_q;

	// Combinational terms.
	logic                      cfg_wr;
	logic                      in_fire;
	logic                      out_free;
	logic                      engage;
	logic [AW-1:0]             wp_next;
	logic [AW-1:0]             prev_idx;
	logic [AW-1:0]             old_idx;
	logic [SPAN_W-1:0]         span_full;
	logic [AW-1:0]             span_idx;
	logic [AW-1:0]             hist_raddr;
	logic [TIME_W-1:0]         hist_rdata;
	logic                      hist_we;
	logic                      scl_ge;
	logic [TIME_W-1:0]         scl_mag;
	logic                      hist_ge;
	logic [TIME_W-1:0]         hist_mag;
	logic [TIME_W-1:0]         quo48;
	logic signed [WIDE_W-1:0]  quo_w;
	logic signed [WIDE_W-1:0]  mean_val;
	logic signed [WIDE_W-1:0]  sp_w;
	logic signed [WIDE_W-1:0]  last_out_w;
	logic                      step_ge;
	logic [WIDE_W:0]           step_mag;
	logic signed [WIDE_W-1:0]  smooth_sum;
	logic signed [WIDE_W-1:0]  lim_hi;
	logic signed [WIDE_W-1:0]  lim_lo;
	logic signed [WIDE_W-1:0]  clamped;
	logic signed [WIDE_W-1:0]  floor_w;
	logic [MUL_A_W-1:0]        mul_a;
	logic [PROD_W-1:0]         mul_p;
	logic signed [TIME_W-1:0]  scl_delta;
	logic [TIME_W-1:0]         scaled_time;
	logic signed [TIME_W-1:0]  hist_delta;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	// Configuration port: zero-wait writes and reads.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_TIME_SCALE:     prdata = PDATA_W'(time_scale_q);
			REG_FILTER_DISABLE: prdata = PDATA_W'(filter_disable_q);
			default:            prdata = '0;
		endcase
	end

	// Channel handshakes.
	assign timestamp.ready        = (state_q == S_IDLE);
	assign in_fire                = timestamp.valid & timestamp.ready;
	assign out_free               = !res_valid_q || smoothed.ready;
	assign smoothed.valid         = res_valid_q;
	assign smoothed.filtered_time = res_time_q;
	assign smoothed.frame_delta   = res_delta_q;

	assign engage = !filter_disable_q && (cnt_q > ENGAGE_S);

	// Ring indices: newest entry and the one a span of samples before it.
	always_comb begin
		wp_next   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
		prev_idx  = (wp_q == '0) ? AW'(HISTORY_DEPTH - 1) : wp_q - AW'(1);
		span_full = {1'b0, cnt_q};
		if (span_full >= SPAN_W'(HISTORY_DEPTH)) begin
			span_full = span_full - SPAN_W'(HISTORY_DEPTH);
		end
		span_idx = span_full[AW-1:0];
		if (prev_idx >= span_idx) begin
			old_idx = prev_idx - span_idx;
		end else begin
			old_idx = AW'({1'b0, prev_idx} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, span_idx});
		end
		hist_raddr = (state_q == S_RD_OLDEST) ? old_idx : prev_idx;
	end

	assign hist_we = (state_q == S_OUT) && out_free && (path_q == PATH_HISTORY);

	tdf_history #(
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (raw_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// Magnitudes of raw deltas, taken from two parallel subtractions.
	assign scl_ge   = timestamp.raw_time >= last_raw_q;
	assign scl_mag  = !last_raw_valid_q ? '0 :
			(scl_ge ? timestamp.raw_time - last_raw_q : last_raw_q - timestamp.raw_time);
	assign hist_ge  = newest_q >= hist_rdata;
	assign hist_mag = hist_ge ? newest_q - hist_rdata : hist_rdata - newest_q;

	// Signed views of the divider result and the filter state.
	assign quo48      = div_rsp.quotient[TIME_W-1:0];
	assign quo_w      = $signed({2'b00, quo48});
	assign mean_val   = sgn_q ? -quo_w : quo_w;
	assign sp_w       = $signed({{(WIDE_W - TIME_W){sp_q[TIME_W-1]}}, sp_q});
	assign last_out_w = $signed({2'b00, last_out_q});

	// Rounded magnitude of the smoothing error, ready for division by ten.
	assign step_ge  = mean_q >= sp_w;
	assign step_mag = step_ge ?
			{mean_q[WIDE_W-1], mean_q} - {sp_w[WIDE_W-1], sp_w} + SMOOTH_ROUND :
			{sp_w[WIDE_W-1], sp_w} - {mean_q[WIDE_W-1], mean_q} + SMOOTH_ROUND;
	assign smooth_sum = sgn_q ? sp_w - quo_w : sp_w + quo_w;

	// Prediction window around the raw sample, then the floor at the last output.
	assign lim_hi  = $signed({2'b00, raw_q}) + $signed({2'b00, CLAMP_WINDOW});
	assign lim_lo  = $signed({2'b00, raw_q}) - $signed({2'b00, CLAMP_WINDOW});
	assign clamped = (pred_q > lim_hi) ? lim_hi : ((pred_q < lim_lo) ? lim_lo : pred_q);
	assign floor_w = (pred_q < last_out_w) ? last_out_w : pred_q;

	// Shared multiplier: upper magnitude bits first, then the fraction.
	assign mul_a = (state_q == S_MUL_HI) ? mag_q[TIME_W-1:FRAC_W] :
			MUL_A_W'(mag_q[FRAC_W-1:0]);
	assign mul_p = mul_a * time_scale_q;

	// Scaled delta, saturated in sign-magnitude form.
	always_comb begin
		if (neg_q) begin
			scl_delta = (acc_q >= ACC_W'(S48_MIN)) ? S48_MIN : TIME_W'(0) - acc_q[TIME_W-1:0];
		end else begin
			scl_delta = (acc_q > ACC_W'(S48_MAX)) ? S48_MAX : acc_q[TIME_W-1:0];
		end
	end

	assign scaled_time = sat_unsigned(last_out_w +
			$signed({{(WIDE_W - TIME_W){delta_q[TIME_W-1]}}, delta_q}));
	assign hist_delta  = (cnt_q == COUNT_RESET) ? FIRST_DELTA :
			sat_signed($signed({2'b00, sample_q}) - last_out_w);

	// Divider requests: mean period by sample count, then step by ten.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DIV_W'(hist_mag);
		div_req.divisor  = cnt_q[DIVISOR_W-1:0];
		if (state_q == S_DIFF) begin
			div_req.start = 1'b1;
		end else if ((state_q == S_STEP) && (sp_q != '0)) begin
			div_req.start    = 1'b1;
			div_req.dividend = DIV_W'(step_mag);
			div_req.divisor  = SMOOTH_DIVISOR;
		end
	end

	tdf_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, configuration registers and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			path_q           <= PATH_HISTORY;
			time_scale_q     <= UNITY_SCALE;
			filter_disable_q <= 1'b0;
			wp_q             <= '0;
			cnt_q            <= COUNT_RESET;
			sp_q             <= '0;
			last_out_q       <= '0;
			last_raw_valid_q <= 1'b0;
			res_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[REG_SEL_BIT])
					REG_TIME_SCALE:     time_scale_q <= pwdata[SCALE_W-1:0];
					REG_FILTER_DISABLE: filter_disable_q <= pwdata[0];
					default:            ;
				endcase
			end
			// The result beat leaves unless a new one replaces it at this edge.
			if (smoothed.ready && !((state_q == S_OUT) && out_free)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					if (timestamp.operation == OP_RESTART) begin
						path_q  <= PATH_RESTART;
						state_q <= S_OUT;
					end else if (time_scale_q != UNITY_SCALE) begin
						path_q  <= PATH_SCALED;
						state_q <= S_MUL_HI;
					end else if (engage) begin
						path_q  <= PATH_HISTORY;
						state_q <= S_RD_NEWEST;
					end else begin
						path_q  <= PATH_HISTORY;
						state_q <= S_OUT;
					end
				end
				S_RD_NEWEST: state_q <= S_RD_OLDEST;
				S_RD_OLDEST: state_q <= S_DIFF;
				S_DIFF:      state_q <= S_DIV_MEAN;
				S_DIV_MEAN: if (div_rsp.done) begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (sp_q == '0) begin
						sp_q    <= $signed(mean_q[TIME_W-1:0]);
						state_q <= S_PRED;
					end else begin
						state_q <= S_DIV_STEP;
					end
				end
				S_DIV_STEP: if (div_rsp.done) begin
					state_q <= S_SMOOTH;
				end
				S_SMOOTH: begin
					sp_q    <= sat_signed(smooth_sum);
					state_q <= S_PRED;
				end
				S_PRED:    state_q <= S_CLAMP;
				S_CLAMP:   state_q <= S_FLOOR;
				S_FLOOR:   state_q <= S_OUT;
				S_MUL_HI:  state_q <= S_MUL_LO;
				S_MUL_LO:  state_q <= S_MUL_ACC;
				S_MUL_ACC: state_q <= S_SAT;
				S_SAT:     state_q <= S_OUT;
				S_OUT: if (out_free) begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					unique case (path_q)
						PATH_RESTART: begin
							wp_q             <= '0;
							cnt_q            <= COUNT_RESET;
							sp_q             <= '0;
							last_out_q       <= '0;
							last_raw_valid_q <= 1'b0;
						end
						PATH_SCALED: begin
							last_out_q       <= scaled_time;
							last_raw_valid_q <= 1'b1;
						end
						default: begin
							wp_q       <= wp_next;
							last_out_q <= sample_q;
							if (cnt_q < MAX_SPAN_S) begin
								cnt_q <= cnt_q + COUNT_W'(1);
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_fire) begin
				raw_q    <= timestamp.raw_time;
				sample_q <= timestamp.raw_time;
				mag_q    <= scl_mag;
				neg_q    <= last_raw_valid_q && !scl_ge;
			end
			S_RD_OLDEST: newest_q <= hist_rdata;
			S_DIFF:      sgn_q <= !hist_ge;
			S_DIV_MEAN: if (div_rsp.done) begin
				mean_q <= mean_val;
			end
			S_STEP:      sgn_q <= !step_ge;
			S_PRED:      pred_q <= last_out_w + sp_w;
			S_CLAMP:     pred_q <= clamped;
			S_FLOOR:     sample_q <= sat_unsigned(floor_w);
			S_MUL_HI:    acc_q <= ACC_W'(mul_p);
			S_MUL_LO:    prod_q <= mul_p;
			S_MUL_ACC:   acc_q <= acc_q + ACC_W'(prod_q[PROD_W-1:FRAC_W]) +
					ACC_W'(prod_q[FRAC_W-1]);
			S_SAT:       delta_q <= scl_delta;
			S_OUT: if (out_free) begin
				unique case (path_q)
					PATH_RESTART: begin
						res_time_q  <= '0;
						res_delta_q <= '0;
					end
					PATH_SCALED: begin
						res_time_q  <= scaled_time;
						res_delta_q <= delta_q;
						last_raw_q  <= raw_q;
					end
					default: begin
						res_time_q  <= sample_q;
						res_delta_q <= hist_delta;
					end
				endcase
			end
			default: ;
		endcase
	end

	// The divider only completes while the sequencer waits for it.
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
			div_rsp.done |-> (state_q == S_DIV_MEAN || state_q == S_DIV_STEP))
		else $error("divider finished outside a wait state");

	// Every history write is followed by a result beat on offer.
	a_write_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
			hist_we |=> res_valid_q)
		else $error("history written without a result");

	// The sample count stays between its restart value and the span limit.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
			(cnt_q >= COUNT_RESET) && (cnt_q <= MAX_SPAN_S))
		else $error("sample count out of range");

	// No new beat is taken while an item is in work.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
			in_fire |=> !timestamp.ready)
		else $error("beat accepted while busy");

endmodule

// ----- tb/timestamp_dejitter_filter_top_test.sv -----
// Self-checking testbench for the timestamp de-jitter filter top level.
// A scoreboard class predicts every result beat from the accepted input beats and checks
// the output stream. Depends on tdf_pkg, the tdf stream interfaces and the filter RTL.

// Filter geometry, shared by the predictor and the instance under test.
localparam int RING_DEPTH   = 32;
localparam int SPAN_LIMIT   = 30;
localparam int ENGAGE_AFTER = 8;

class tdf_scoreboard;
	typedef struct {
		logic [tdf_pkg::TIME_W-1:0] filtered_time;
		logic [tdf_pkg::TIME_W-1:0] frame_delta;
	} smoothed_beat_t;

	localparam int     SPAN_RESTART = -2;
	localparam longint S48_HI       = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint S48_LO       = -64'sh0000_8000_0000_0000;
	localparam longint U48_HI       = 64'sh0000_FFFF_FFFF_FFFF;
	localparam int     PRINT_LIMIT  = 200;

	smoothed_beat_t expected_q[$];
	int unsigned    mismatches;
	int unsigned    results_seen;

	// Register copies.
	logic [tdf_pkg::SCALE_W-1:0] scale;
	logic                        bypass;

	// Filter state as the block should hold it.
	logic [tdf_pkg::TIME_W-1:0] ring [RING_DEPTH];
	int                         ring_wr;
	int                         span;
	longint                     period;
	logic [tdf_pkg::TIME_W-1:0] last_out;
	logic [tdf_pkg::TIME_W-1:0] last_in;
	bit                         last_in_ok;

	function new();
		scale        = tdf_pkg::UNITY_SCALE;
		bypass       = 1'b0;
		mismatches   = 0;
		results_seen = 0;
		foreach (ring[i]) ring[i] = '0;
		clear_tracking();
	endfunction

	function void clear_tracking();
		ring_wr    = 0;
		span       = SPAN_RESTART;
		period     = 0;
		last_out   = '0;
		last_in    = '0;
		last_in_ok = 1'b0;
	endfunction

	function longint widen(logic [tdf_pkg::TIME_W-1:0] v);
		return longint'({16'b0, v});
	endfunction

	function longint clip_s48(longint v);
		if (v > S48_HI) return S48_HI;
		if (v < S48_LO) return S48_LO;
		return v;
	endfunction

	function logic [tdf_pkg::TIME_W-1:0] clip_u48(longint v);
		if (v < 0) return '0;
		if (v > U48_HI) return '1;
		return v[tdf_pkg::TIME_W-1:0];
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void set_register(logic sel, logic [tdf_pkg::PDATA_W-1:0] value);
		if (sel == tdf_pkg::REG_TIME_SCALE) begin
			scale = value[tdf_pkg::SCALE_W-1:0];
		end else begin
			bypass = value[0];
		end
	endfunction

	// Work out the result of one accepted input beat and queue it.
	function void note_beat(logic op, logic [tdf_pkg::TIME_W-1:0] raw);
		smoothed_beat_t             exp_beat;
		longint                     delta, diff, mag, mean, step, pred, lim_hi, lim_lo, fil;
		logic [63:0]                umag, hi_part, lo_part, prod;
		logic [tdf_pkg::TIME_W-1:0] sample;
		int                         newest, oldest;
		sample = raw;
		if (op == tdf_pkg::OP_RESTART) begin
			clear_tracking();
			exp_beat.filtered_time = '0;
			exp_beat.frame_delta   = '0;
		end else if (scale != tdf_pkg::UNITY_SCALE) begin
			// Scaled mode: the raw delta times the scale, rounded half away from zero.
			diff    = last_in_ok ? widen(raw) - widen(last_in) : 0;
			umag    = (diff < 0) ? -diff : diff;
			hi_part = (umag >> 16) * scale;
			lo_part = (umag & 64'hFFFF) * scale;
			prod    = hi_part + ((lo_part + 64'h8000) >> 16);
			if (diff < 0) begin
				delta = (prod >= 64'h8000_0000_0000) ? S48_LO : -longint'(prod);
			end else begin
				delta = (prod > 64'h7FFF_FFFF_FFFF) ? S48_HI : longint'(prod);
			end
			last_in    = raw;
			last_in_ok = 1'b1;
			last_out   = clip_u48(widen(last_out) + delta);
			exp_beat.filtered_time = last_out;
			exp_beat.frame_delta   = delta[tdf_pkg::TIME_W-1:0];
		end else begin
			// Once enough history exists, predict from the smoothed mean period.
			if (!bypass && span > ENGAGE_AFTER) begin
				newest = (ring_wr + RING_DEPTH - 1) % RING_DEPTH;
				oldest = (newest + RING_DEPTH - span % RING_DEPTH) % RING_DEPTH;
				diff   = widen(ring[newest]) - widen(ring[oldest]);
				mag    = ((diff < 0) ? -diff : diff) / span;
				mean   = (diff < 0) ? -mag : mag;
				if (period == 0) period = mean;
				diff   = mean - period;
				mag    = (((diff < 0) ? -diff : diff) + 5) / 10;
				step   = (diff < 0) ? -mag : mag;
				period = clip_s48(period + step);
				pred   = widen(last_out) + period;
				lim_hi = widen(raw) + longint'(tdf_pkg::CLAMP_WINDOW);
				lim_lo = widen(raw) - longint'(tdf_pkg::CLAMP_WINDOW);
				fil    = (pred > lim_hi) ? lim_hi : ((pred < lim_lo) ? lim_lo : pred);
				if (fil < widen(last_out)) fil = widen(last_out);
				sample = clip_u48(fil);
			end
			ring[ring_wr] = raw;
			ring_wr       = (ring_wr + 1) % RING_DEPTH;
			if (span == SPAN_RESTART) begin
				delta = longint'(tdf_pkg::FIRST_DELTA);
			end else begin
				delta = clip_s48(widen(sample) - widen(last_out));
			end
			if (span < SPAN_LIMIT) span++;
			last_out = sample;
			exp_beat.filtered_time = sample;
			exp_beat.frame_delta   = delta[tdf_pkg::TIME_W-1:0];
		end
		expected_q.push_back(exp_beat);
	endfunction

	// Print one line per mismatch, up to a cap, and count every one.
	function void report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT) $display("%s", msg);
		mismatches++;
	endfunction

	// Compare a result beat with the oldest outstanding prediction.
	function void check_result(logic [tdf_pkg::TIME_W-1:0] ft, logic [tdf_pkg::TIME_W-1:0] fd);
		smoothed_beat_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("result %0d: unexpected beat, time %h delta %h",
				results_seen, ft, fd));
			return;
		end
		want = expected_q.pop_front();
		if (ft !== want.filtered_time) begin
			report_mismatch($sformatf("result %0d: filtered_time %h, predicted %h",
				results_seen, ft, want.filtered_time));
		end
		if (fd !== want.frame_delta) begin
			report_mismatch($sformatf("result %0d: frame_delta %h, predicted %h",
				results_seen, fd, want.frame_delta));
		end
	endfunction
endclass

module timestamp_dejitter_filter_top_test;
	import tdf_pkg::*;

	localparam int     RUN_LIMIT    = 5_000_000;
	localparam int     SETTLE_TICKS = 50;
	localparam longint FRAME_PERIOD = longint'(FIRST_DELTA);
	localparam longint MS           = 65536;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	tdf_in_if  timestamp_if ();
	tdf_out_if smoothed_if ();

	tdf_scoreboard     sb;
	int unsigned       sender_idle_pct;
	int unsigned       receiver_stall_pct;
	logic [TIME_W-1:0] stream_time;

	timestamp_dejitter_filter_top #(
		.HISTORY_DEPTH(RING_DEPTH),
		.MAX_SPAN     (SPAN_LIMIT),
		.ENGAGE_COUNT (ENGAGE_AFTER)
	) dut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.timestamp(timestamp_if),
		.smoothed (smoothed_if)
	);

	// Free-running clock, period 10.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hung run fails.
	initial begin
		#RUN_LIMIT;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [TIME_W-1:0] random48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	// Starting point of a new timestamp stream: low, anywhere, or close to the top.
	function automatic logic [TIME_W-1:0] fresh_base();
		case ($urandom_range(3))
			0: return TIME_W'($urandom_range(32'h00FF_FFFF));
			1: return random48();
			2: return '1 - TIME_W'($urandom_range(32'h0400_0000));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	// Offer one input beat, with random idle cycles first, and hold it until taken.
	task automatic send_beat(input logic op, input logic [TIME_W-1:0] raw);
		while ($urandom_range(99) < sender_idle_pct) begin
			timestamp_if.valid     <= 1'b0;
			timestamp_if.operation <= 1'($urandom_range(1));
			timestamp_if.raw_time  <= random48();
			@(posedge clk);
		end
		timestamp_if.valid     <= 1'b1;
		timestamp_if.operation <= op;
		timestamp_if.raw_time  <= raw;
		do @(posedge clk); while (!timestamp_if.ready);
		sb.note_beat(op, raw);
	endtask

	// Stop sending and wait until every predicted result has been seen.
	task automatic drain_results();
		timestamp_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// APB write: setup phase, access phase, then the bus returns to idle.
	task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
		logic [PADDR_W-1:0] addr;
		addr              = '0;
		addr[REG_SEL_BIT] = sel;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(sel, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only once the block has gone quiet.
	task automatic configure(input logic [SCALE_W-1:0] scale, input logic bypass);
		drain_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		write_reg(REG_TIME_SCALE, PDATA_W'(scale));
		write_reg(REG_FILTER_DISABLE, PDATA_W'(bypass));
	endtask

	// Mostly a jittered frame cadence, with restarts, wild values and backward steps.
	task automatic send_random_beat();
		int     roll;
		longint step;
		roll = $urandom_range(99);
		if (roll < 3) begin
			send_beat(OP_RESTART, random48());
			stream_time = fresh_base();
		end else if (roll < 7) begin
			send_beat(OP_SAMPLE, random48());
		end else begin
			if (roll < 11) begin
				step = -longint'($urandom_range(40 * MS));
			end else if (roll < 20) begin
				step = FRAME_PERIOD + longint'($urandom_range(60 * MS)) - 30 * MS;
			end else begin
				step = FRAME_PERIOD + longint'($urandom_range(6 * MS)) - 3 * MS;
			end
			stream_time = stream_time + step[TIME_W-1:0];
			send_beat(OP_SAMPLE, stream_time);
		end
	endtask

	// One random phase under a given register setting and handshake pressure.
	task automatic run_phase(input int n, input int unsigned idle, input int unsigned stall,
			input logic [SCALE_W-1:0] scale, input logic bypass);
		configure(scale, bypass);
		sender_idle_pct    = idle;
		receiver_stall_pct = stall;
		stream_time        = fresh_base();
		for (int i = 0; i < n; i++) begin
			// Halfway through, let the output side empty completely.
			if (i == n / 2) drain_results();
			send_random_beat();
		end
	endtask

	initial begin
		longint t;
		timestamp_if.valid     <= 1'b0;
		timestamp_if.operation <= OP_SAMPLE;
		timestamp_if.raw_time  <= '0;
		smoothed_if.ready      <= 1'b0;
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		stream_time        = '0;
		sb                 = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Result side: check each accepted beat, then choose ready for the next cycle.
		fork
			forever begin
				@(posedge clk);
				if (smoothed_if.valid && smoothed_if.ready) begin
					sb.check_result(smoothed_if.filtered_time, smoothed_if.frame_delta);
				end
				smoothed_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		join_none

		// Directed: first delta, a steady cadence until the filter engages, then clamps.
		send_beat(OP_SAMPLE, '0);
		for (int k = 1; k <= 12; k++) begin
			t = k * FRAME_PERIOD + ((k % 2 == 1) ? 2 * MS : -2 * MS);
			send_beat(OP_SAMPLE, t[TIME_W-1:0]);
		end
		send_beat(OP_SAMPLE, '1);
		send_beat(OP_SAMPLE, '0);
		send_beat(OP_RESTART, '1);

		// Directed: scaled mode at the largest scale saturates both ways.
		configure('1, 1'b0);
		send_beat(OP_SAMPLE, '1);
		send_beat(OP_SAMPLE, '0);
		send_beat(OP_SAMPLE, '1);

		// Directed: zero scale gives zero deltas.
		configure('0, 1'b0);
		send_beat(OP_SAMPLE, 48'h1234_5678_9ABC);
		send_beat(OP_SAMPLE, '0);

		// Directed: bypass follows raw samples.
		configure(UNITY_SCALE, 1'b1);
		send_beat(OP_SAMPLE, 48'h5555_5555_5555);
		send_beat(OP_SAMPLE, 48'hAAAA_AAAA_AAAA);
		send_beat(OP_RESTART, '0);

		// Random phases across register settings and handshake pressure.
		run_phase(120, 0, 0, UNITY_SCALE, 1'b0);
		run_phase(100, 88, 0, UNITY_SCALE, 1'b0);
		run_phase(100, 0, 88, UNITY_SCALE, 1'b1);
		run_phase(100, 10, 10, SCALE_W'($urandom_range(32'h00FF_FFFF)), 1'b0);
		run_phase(80, 0, 0, UNITY_SCALE + 1'b1, 1'b1);
		run_phase(200, 10, 10, UNITY_SCALE, 1'b0);

		drain_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/tdf_pkg.sv
src/tdf_stream_if.sv
src/tdf_divider.sv
src/tdf_history.sv
src/timestamp_dejitter_filter_top.sv
tb/timestamp_dejitter_filter_top_test.sv
